### design/hdist_pkg.sv
// shared widths, constants and the arctangent table of the haversine distance pipeline
// no dependencies; used by every module in this folder
package hdist_pkg;

   localparam int CORDIC_STAGES_DEF = 24;

   localparam int LAT_W    = 24;
   localparam int LON_W    = 25;
   localparam int ANGLE_W  = 26;
   localparam int RADIUS_W = 16;
   localparam int DIST_W   = 28;

   localparam int LANES      = 4;
   localparam int ROOT_LANES = 2;

   localparam int TURN_W = 28;
   localparam int RED_W  = 23;
   localparam logic signed [TURN_W-1:0] FULL_TURN    = 28'sd23592960;
   localparam logic signed [TURN_W-1:0] HALF_TURN    = 28'sd11796480;
   localparam logic signed [TURN_W-1:0] QUARTER_TURN = 28'sd5898240;

   // round(pi / 180 * 2^46)
   localparam logic [40:0] DEG_TO_RAD = 41'd1228166276394;
   localparam int PHI_W = 44;
   localparam int PLO_W = 43;

   localparam int CW    = 34;
   localparam int COS_W = 32;
   localparam logic signed [CW-1:0] GAIN_INV = 34'sd652032874;
   localparam logic signed [CW-1:0] ONE_CW   = 34'sd1073741824;

   localparam int HAV_W = 31;
   localparam int A_W   = 31;

   localparam int ROOT_STEPS  = 31;
   localparam int ROOT_W      = 31;
   localparam int RADICAND_W  = 62;

   localparam int ZW     = 31;
   localparam int KILO_W = 26;
   localparam int MUL_W  = 58;
   localparam logic [DIST_W-1:0] DIST_MAX = 28'd205881000;

   // round(atan(2^-i) * 2^30)
   function automatic logic [29:0] atan_q30(input logic [4:0] i);
      logic [29:0] v;
      case (i)
         5'd0:  v = 30'd843314857;
         5'd1:  v = 30'd497837829;
         5'd2:  v = 30'd263043837;
         5'd3:  v = 30'd133525159;
         5'd4:  v = 30'd67021687;
         5'd5:  v = 30'd33543516;
         5'd6:  v = 30'd16775851;
         5'd7:  v = 30'd8388437;
         5'd8:  v = 30'd4194283;
         5'd9:  v = 30'd2097149;
         5'd10: v = 30'd1048576;
         5'd11: v = 30'd524288;
         5'd12: v = 30'd262144;
         5'd13: v = 30'd131072;
         5'd14: v = 30'd65536;
         5'd15: v = 30'd32768;
         5'd16: v = 30'd16384;
         5'd17: v = 30'd8192;
         5'd18: v = 30'd4096;
         5'd19: v = 30'd2048;
         5'd20: v = 30'd1024;
         5'd21: v = 30'd512;
         5'd22: v = 30'd256;
         5'd23: v = 30'd128;
         5'd24: v = 30'd64;
         5'd25: v = 30'd32;
         5'd26: v = 30'd16;
         5'd27: v = 30'd8;
         5'd28: v = 30'd4;
         5'd29: v = 30'd2;
         5'd30: v = 30'd1;
         default: v = 30'd1;
      endcase
      return v;
   endfunction

endpackage

### design/hdist_cos.sv
// four-lane cosine pipeline: angle folding, degree to radian product, rotation cordic
// depends on hdist_pkg
module hdist_cos #(
   parameter int STAGES = hdist_pkg::CORDIC_STAGES_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   enable,
   input  logic                                   in_valid,
   input  logic signed [hdist_pkg::ANGLE_W-1:0]   in_angle [0:hdist_pkg::LANES-1],
   output logic                                   out_valid,
   output logic signed [hdist_pkg::COS_W-1:0]     out_cos  [0:hdist_pkg::LANES-1]
);
   import hdist_pkg::*;

   logic [STAGES+3:0]       vld_ff;
   logic [RED_W-1:0]        red_in  [0:LANES-1];
   logic [LANES-1:0]        neg_in;
   logic [RED_W-1:0]        red_ff  [0:LANES-1];
   logic [LANES-1:0]        neg_a_ff;
   logic [PHI_W-1:0]        phi_ff  [0:LANES-1];
   logic [PLO_W-1:0]        plo_ff  [0:LANES-1];
   logic [LANES-1:0]        neg_b_ff;
   logic signed [CW-1:0]    x_ff    [0:STAGES][0:LANES-1];
   logic signed [CW-1:0]    y_ff    [0:STAGES][0:LANES-1];
   logic signed [CW-1:0]    z_ff    [0:STAGES][0:LANES-1];
   logic [LANES-1:0]        neg_ff  [0:STAGES];
   logic signed [COS_W-1:0] cos_in  [0:LANES-1];

   // reduce to [0, 90] degrees with a sign for the cosine
   always_comb begin
      logic signed [TURN_W-1:0] t;
      for (int l = 0; l < LANES; l++) begin
         t = TURN_W'(in_angle[l]);
         if (t < 0) t = t + FULL_TURN;
         if (t < 0) t = t + FULL_TURN;
         if (t >= FULL_TURN) t = t - FULL_TURN;
         if (t > HALF_TURN) t = FULL_TURN - t;
         neg_in[l] = (t > QUARTER_TURN);
         if (neg_in[l]) t = HALF_TURN - t;
         red_in[l] = t[RED_W-1:0];
      end
   end

   always_comb begin
      logic signed [CW-1:0] xf;
      for (int l = 0; l < LANES; l++) begin
         xf = x_ff[STAGES][l];
         if (xf < 0) xf = '0;
         else if (xf > ONE_CW) xf = ONE_CW;
         cos_in[l] = neg_ff[STAGES][l] ? -COS_W'(xf) : COS_W'(xf);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (enable) begin
         vld_ff <= {vld_ff[STAGES+2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      logic [63:0] sum;
      if (enable) begin
         red_ff   <= red_in;
         neg_a_ff <= neg_in;
         neg_b_ff <= neg_a_ff;
         neg_ff[0] <= neg_b_ff;
         for (int l = 0; l < LANES; l++) begin
            phi_ff[l] <= PHI_W'(red_ff[l]) * PHI_W'(DEG_TO_RAD[40:20]);
            plo_ff[l] <= PLO_W'(red_ff[l]) * PLO_W'(DEG_TO_RAD[19:0]);
            sum = {phi_ff[l], 20'b0} + 64'(plo_ff[l]) + 64'h8000_0000;
            x_ff[0][l] <= GAIN_INV;
            y_ff[0][l] <= '0;
            z_ff[0][l] <= CW'(sum[63:32]);
            out_cos[l] <= cos_in[l];
         end
      end
   end

   for (genvar k = 0; k < STAGES; k++) begin : g_rot
      localparam logic signed [CW-1:0] ANG = CW'(atan_q30(5'(k)));
      always_ff @(posedge clock) begin
         if (enable) begin
            neg_ff[k+1] <= neg_ff[k];
            for (int l = 0; l < LANES; l++) begin
               if (!z_ff[k][l][CW-1]) begin
                  x_ff[k+1][l] <= x_ff[k][l] - (y_ff[k][l] >>> k);
                  y_ff[k+1][l] <= y_ff[k][l] + (x_ff[k][l] >>> k);
                  z_ff[k+1][l] <= z_ff[k][l] - ANG;
               end else begin
                  x_ff[k+1][l] <= x_ff[k][l] + (y_ff[k][l] >>> k);
                  y_ff[k+1][l] <= y_ff[k][l] - (x_ff[k][l] >>> k);
                  z_ff[k+1][l] <= z_ff[k][l] + ANG;
               end
            end
         end
      end
   end

   assign out_valid = vld_ff[STAGES+3];

endmodule

### design/hdist_sqrt.sv
// two-lane integer square root, one result bit per pipeline stage
// depends on hdist_pkg
module hdist_sqrt (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  enable,
   input  logic                                  in_valid,
   input  logic [hdist_pkg::RADICAND_W-1:0]      in_value [0:hdist_pkg::ROOT_LANES-1],
   output logic                                  out_valid,
   output logic [hdist_pkg::ROOT_W-1:0]          out_root [0:hdist_pkg::ROOT_LANES-1]
);
   import hdist_pkg::*;

   logic [ROOT_STEPS:0]     vld_ff;
   logic [RADICAND_W-1:0]   v_ff [0:ROOT_STEPS][0:ROOT_LANES-1];
   logic [RADICAND_W-1:0]   r_ff [0:ROOT_STEPS][0:ROOT_LANES-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (enable) begin
         vld_ff <= {vld_ff[ROOT_STEPS-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int l = 0; l < ROOT_LANES; l++) begin
            v_ff[0][l] <= in_value[l];
            r_ff[0][l] <= '0;
         end
      end
   end

   for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_step
      localparam logic [RADICAND_W-1:0] STEP_BIT =
         RADICAND_W'(1) << (2 * (ROOT_STEPS - 1 - k));
      always_ff @(posedge clock) begin
         if (enable) begin
            for (int l = 0; l < ROOT_LANES; l++) begin
               if (v_ff[k][l] >= r_ff[k][l] + STEP_BIT) begin
                  v_ff[k+1][l] <= v_ff[k][l] - (r_ff[k][l] + STEP_BIT);
                  r_ff[k+1][l] <= (r_ff[k][l] >> 1) + STEP_BIT;
               end else begin
                  v_ff[k+1][l] <= v_ff[k][l];
                  r_ff[k+1][l] <= r_ff[k][l] >> 1;
               end
            end
         end
      end
   end

   for (genvar l = 0; l < ROOT_LANES; l++) begin : g_out
      assign out_root[l] = r_ff[ROOT_STEPS][l][ROOT_W-1:0];
   end

   assign out_valid = vld_ff[ROOT_STEPS];

endmodule

### design/hdist_atan.sv
// vectoring cordic giving the central half angle atan2(y, x) in q30 radians
// depends on hdist_pkg
module hdist_atan #(
   parameter int STAGES = hdist_pkg::CORDIC_STAGES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          enable,
   input  logic                          in_valid,
   input  logic [hdist_pkg::ROOT_W-1:0]  in_x,
   input  logic [hdist_pkg::ROOT_W-1:0]  in_y,
   output logic                          out_valid,
   output logic [hdist_pkg::ZW-1:0]      out_angle
);
   import hdist_pkg::*;

   logic [STAGES+1:0]    vld_ff;
   logic signed [CW-1:0] x_ff [0:STAGES];
   logic signed [CW-1:0] y_ff [0:STAGES];
   logic signed [CW-1:0] z_ff [0:STAGES];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (enable) begin
         vld_ff <= {vld_ff[STAGES:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff[0] <= CW'(in_x);
         y_ff[0] <= CW'(in_y);
         z_ff[0] <= '0;
         out_angle <= z_ff[STAGES][CW-1] ? '0 : z_ff[STAGES][ZW-1:0];
      end
   end

   for (genvar k = 0; k < STAGES; k++) begin : g_vec
      localparam logic signed [CW-1:0] ANG = CW'(atan_q30(5'(k)));
      always_ff @(posedge clock) begin
         if (enable) begin
            if (y_ff[k] > 0) begin
               x_ff[k+1] <= x_ff[k] + (y_ff[k] >>> k);
               y_ff[k+1] <= y_ff[k] - (x_ff[k] >>> k);
               z_ff[k+1] <= z_ff[k] + ANG;
            end else begin
               x_ff[k+1] <= x_ff[k] - (y_ff[k] >>> k);
               y_ff[k+1] <= y_ff[k] + (x_ff[k] >>> k);
               z_ff[k+1] <= z_ff[k] - ANG;
            end
         end
      end
   end

   assign out_valid = vld_ff[STAGES+1];

endmodule

### design/haversine_distance_top.sv
// channel  direction  fields
// req_     in         first_latitude, first_longitude, second_latitude, second_longitude
// rsp_     out        distance_meters
// csr_     in         sphere_radius_km (write only)
// one transaction per cycle while no result waits under rsp_stall; the path runs through the
// two cordic chains and the 31-step square root
// the whole pipeline holds while a result waits under rsp_stall
// reset clears the valid bits and sets the radius to 6371 km
// haversine distance top level; depends on hdist_pkg, hdist_cos, hdist_sqrt, hdist_atan
module haversine_distance_top #(
   parameter int CORDIC_STAGES = hdist_pkg::CORDIC_STAGES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [hdist_pkg::LAT_W-1:0] req_first_latitude,
   input  logic signed [hdist_pkg::LON_W-1:0] req_first_longitude,
   input  logic signed [hdist_pkg::LAT_W-1:0] req_second_latitude,
   input  logic signed [hdist_pkg::LON_W-1:0] req_second_longitude,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [hdist_pkg::DIST_W-1:0]      rsp_distance_meters,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [hdist_pkg::RADIUS_W-1:0]    csr_sphere_radius_km
);
   import hdist_pkg::*;

   logic                    adv;
   logic [RADIUS_W-1:0]     radius_ff;
   logic [KILO_W-1:0]       kilo_ff;

   logic                    v0_ff;
   logic signed [ANGLE_W-1:0] ang_ff [0:LANES-1];
   logic                    cos_valid;
   logic signed [COS_W-1:0] cos_val [0:LANES-1];

   logic                    v1_ff, v2_ff, v3_ff, v4_ff, rsp_valid_ff;
   logic [HAV_W-1:0]        hlat_ff, hlon_ff, hlat2_ff;
   logic signed [63:0]      prod_ff, ph_ff;
   logic [A_W-1:0]          a_ff;
   logic [RADICAND_W-1:0]   rad_in [0:ROOT_LANES-1];
   logic                    root_valid;
   logic [ROOT_W-1:0]       root [0:ROOT_LANES-1];
   logic                    ang_valid;
   logic [ZW-1:0]           half_angle;
   logic [MUL_W-1:0]        mul_ff;
   logic [DIST_W-1:0]       dist_in;
   logic [DIST_W-1:0]       rsp_dist_ff;

   logic signed [32:0]      hlat_in, hlon_in;
   logic signed [31:0]      p_in;
   logic signed [32:0]      a_in;

   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_W'(6371);
         kilo_ff   <= KILO_W'(6371000);
      end else begin
         if (csr_valid && csr_ready) radius_ff <= csr_sphere_radius_km;
         kilo_ff <= KILO_W'(radius_ff) * KILO_W'(1000);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff        <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         v0_ff        <= req_valid;
         v1_ff        <= cos_valid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= ang_valid;
         rsp_valid_ff <= v4_ff;
      end
   end

   // lanes: latitude difference, longitude difference, first latitude, second latitude
   always_ff @(posedge clock) begin
      if (adv) begin
         ang_ff[0] <= ANGLE_W'(req_second_latitude) - ANGLE_W'(req_first_latitude);
         ang_ff[1] <= ANGLE_W'(req_second_longitude) - ANGLE_W'(req_first_longitude);
         ang_ff[2] <= ANGLE_W'(req_first_latitude);
         ang_ff[3] <= ANGLE_W'(req_second_latitude);
      end
   end

   hdist_cos #(.STAGES(CORDIC_STAGES)) u_cos (
      .clock     (clock),
      .reset     (reset),
      .enable    (adv),
      .in_valid  (v0_ff),
      .in_angle  (ang_ff),
      .out_valid (cos_valid),
      .out_cos   (cos_val)
   );

   always_comb begin
      hlat_in = (33'sd1073741824 - 33'(cos_val[0])) >>> 1;
      hlon_in = (33'sd1073741824 - 33'(cos_val[1])) >>> 1;
      p_in    = 32'(prod_ff >>> 30);
      a_in    = 33'(hlat2_ff) + 33'(ph_ff >>> 30);
      if (a_in < 0) a_in = '0;
      else if (a_in > 33'sd1073741824) a_in = 33'sd1073741824;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         hlat_ff  <= hlat_in[HAV_W-1:0];
         hlon_ff  <= hlon_in[HAV_W-1:0];
         prod_ff  <= 64'(cos_val[2]) * 64'(cos_val[3]);
         hlat2_ff <= hlat_ff;
         ph_ff    <= 64'(p_in) * 64'(signed'({1'b0, hlon_ff}));
         a_ff     <= a_in[A_W-1:0];
      end
   end

   assign rad_in[0] = RADICAND_W'(a_ff) << 30;
   assign rad_in[1] = RADICAND_W'(A_W'(1 << 30) - a_ff) << 30;

   hdist_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .enable    (adv),
      .in_valid  (v3_ff),
      .in_value  (rad_in),
      .out_valid (root_valid),
      .out_root  (root)
   );

   hdist_atan #(.STAGES(CORDIC_STAGES)) u_atan (
      .clock     (clock),
      .reset     (reset),
      .enable    (adv),
      .in_valid  (root_valid),
      .in_x      (root[1]),
      .in_y      (root[0]),
      .out_valid (ang_valid),
      .out_angle (half_angle)
   );

   always_comb begin
      logic [MUL_W:0] rnd;
      rnd = (MUL_W+1)'(mul_ff) + (MUL_W+1)'(1 << 29);
      if (rnd[MUL_W:30] > (MUL_W-29)'(DIST_MAX)) dist_in = DIST_MAX;
      else dist_in = rnd[DIST_W+29:30];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mul_ff      <= MUL_W'(kilo_ff) * MUL_W'({half_angle, 1'b0});
         rsp_dist_ff <= dist_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_distance_meters = rsp_dist_ff;

endmodule

### test/hdist_scoreboard.sv
// scoreboard for the haversine distance block: predicts each distance from the request
// transactions and the radius register and compares it with the response channel; uses hdist_pkg
`timescale 1ns / 1ps

module hdist_scoreboard (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  logic signed [hdist_pkg::LAT_W-1:0] req_first_latitude,
   input  logic signed [hdist_pkg::LON_W-1:0] req_first_longitude,
   input  logic signed [hdist_pkg::LAT_W-1:0] req_second_latitude,
   input  logic signed [hdist_pkg::LON_W-1:0] req_second_longitude,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  logic [hdist_pkg::DIST_W-1:0]       rsp_distance_meters,
   input  logic                               csr_valid,
   input  logic                               csr_ready,
   input  logic [hdist_pkg::RADIUS_W-1:0]     csr_sphere_radius_km,
   output int                                 error_count,
   output int                                 pending_count,
   output int                                 checked_count
);
   import hdist_pkg::*;

   localparam longint ONE  = 64'sd1 << 30;
   localparam longint FULL = 64'sd23592960;
   localparam longint HALF = 64'sd11796480;
   localparam longint QTR  = 64'sd5898240;
   localparam longint GAIN = 64'sd652032874;
   localparam longint LIMIT_M = 64'sd205881000;
   localparam int STAGES = (CORDIC_STAGES_DEF < 32) ? CORDIC_STAGES_DEF : 32;

   longint arctan_q30 [32];
   longint unsigned rad_per_deg_q46;
   logic [RADIUS_W-1:0] radius_km;
   logic [DIST_W-1:0] distance_fifo [$];

   // atan(1/n) in q62 by alternating series
   function automatic longint unsigned arctan_recip_q62(input longint unsigned n);
      longint unsigned p, acc, k, term;
      p = (64'd1 << 62) / n;
      acc = 0;
      k = 0;
      while (p != 0) begin
         term = p / (2 * k + 1);
         if (k[0] == 1'b0) acc = acc + term;
         else acc = acc - term;
         p = p / n / n;
         k++;
      end
      return acc;
   endfunction

   function automatic longint cos_q30(input longint ang);
      longint r, x, y, z, xs, ys;
      logic flip;
      longint unsigned prod;
      r = ang % FULL;
      if (r < 0) r += FULL;
      if (r > HALF) r = FULL - r;
      flip = r > QTR;
      if (flip) r = HALF - r;
      prod = longint'(unsigned'(r)) * rad_per_deg_q46 + (64'd1 << 31);
      z = longint'(prod >> 32);
      x = GAIN;
      y = 0;
      for (int i = 0; i < STAGES; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x -= ys; y += xs; z -= arctan_q30[i];
         end else begin
            x += ys; y -= xs; z += arctan_q30[i];
         end
      end
      if (x < 0) x = 0;
      if (x > ONE) x = ONE;
      return flip ? -x : x;
   endfunction

   function automatic longint unsigned isqrt(input longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic logic [DIST_W-1:0] great_circle_meters(
      input longint lat1, input longint lon1, input longint lat2, input longint lon2,
      input logic [RADIUS_W-1:0] rkm);
      longint hav_lat, hav_lon, c1, c2, p, a, x, y, z, xs, ys;
      longint unsigned d;
      hav_lat = (ONE - cos_q30(lat2 - lat1)) >>> 1;
      hav_lon = (ONE - cos_q30(lon2 - lon1)) >>> 1;
      c1 = cos_q30(lat1);
      c2 = cos_q30(lat2);
      p = (c1 * c2) >>> 30;
      a = hav_lat + ((p * hav_lon) >>> 30);
      if (a < 0) a = 0;
      if (a > ONE) a = ONE;
      y = longint'(isqrt(longint'(unsigned'(a)) << 30));
      x = longint'(isqrt(longint'(unsigned'(ONE - a)) << 30));
      z = 0;
      for (int i = 0; i < STAGES; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y > 0) begin
            x += ys; y -= xs; z += arctan_q30[i];
         end else begin
            x -= ys; y += xs; z -= arctan_q30[i];
         end
      end
      if (z < 0) z = 0;
      d = (longint'(unsigned'(rkm)) * 1000 * longint'(unsigned'(2 * z)) + (64'd1 << 29)) >> 30;
      if (d > LIMIT_M) d = LIMIT_M;
      return d[DIST_W-1:0];
   endfunction

   initial begin
      longint unsigned quarter_pi;
      quarter_pi = 4 * arctan_recip_q62(5) - arctan_recip_q62(239);
      arctan_q30[0] = longint'((quarter_pi + (64'd1 << 31)) >> 32);
      for (int i = 1; i < 32; i++)
         arctan_q30[i] = longint'((arctan_recip_q62(64'd1 << i) + (64'd1 << 31)) >> 32);
      rad_per_deg_q46 = (quarter_pi / 45 + (64'd1 << 15)) >> 16;
      error_count = 0;
      checked_count = 0;
      pending_count = 0;
      radius_km = 16'd6371;
   end

   always @(posedge clock) begin
      logic [DIST_W-1:0] want;
      if (reset) begin
         radius_km <= 16'd6371;
      end else begin
         if (csr_valid && csr_ready) radius_km <= csr_sphere_radius_km;
         if (req_valid && !req_stall)
            distance_fifo.push_back(great_circle_meters(req_first_latitude,
               req_first_longitude, req_second_latitude, req_second_longitude, radius_km));
         if (rsp_valid && !rsp_stall) begin
            if (distance_fifo.size() == 0) begin
               $error("unexpected transaction, distance_meters %0d", rsp_distance_meters);
               error_count++;
            end else begin
               want = distance_fifo.pop_front();
               checked_count++;
               if (rsp_distance_meters !== want) begin
                  $error("distance_meters expected %0d actual %0d", want, rsp_distance_meters);
                  error_count++;
               end
            end
         end
      end
      pending_count <= distance_fifo.size();
   end
endmodule

### test/tb_haversine_distance_top.sv
// testbench top for haversine_distance_top: drives point pairs and radius settings with
// random gaps and stalls; depends on hdist_pkg, the design and hdist_scoreboard
`timescale 1ns / 1ps

module tb_haversine_distance_top;
   import hdist_pkg::*;

   localparam int DRAIN = 2 * CORDIC_STAGES_DEF + 44 + 30;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int LAT_MAX = 5898240;
   localparam int LON_MAX = 11796480;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [LAT_W-1:0] req_first_latitude = '0;
   logic signed [LON_W-1:0] req_first_longitude = '0;
   logic signed [LAT_W-1:0] req_second_latitude = '0;
   logic signed [LON_W-1:0] req_second_longitude = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [DIST_W-1:0] rsp_distance_meters;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [RADIUS_W-1:0] csr_sphere_radius_km = '0;

   int error_count, pending_count, checked_count;
   int radius_settings = 1;
   int idle_cycles = 0;
   logic no_gaps = 1'b0;
   logic no_stalls = 1'b0;

   always #10 clock = ~clock;

   haversine_distance_top dut (.*);

   hdist_scoreboard sb (.*);

   function automatic int pick_gap(input logic quiet);
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", idle_cycles);
         $display("** haversine_distance_top: FAILED **");
         $finish;
      end
   end

   // receiver stalls in runs
   initial begin
      int len;
      forever begin
         len = pick_gap(no_stalls);
         if (len > 0) begin
            rsp_stall <= 1'b1;
            repeat (len) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
      end
   end

   task automatic send_pair(input int la1, input int lo1, input int la2, input int lo2);
      int gap;
      gap = pick_gap(no_gaps);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_first_latitude <= la1[LAT_W-1:0];
      req_first_longitude <= lo1[LON_W-1:0];
      req_second_latitude <= la2[LAT_W-1:0];
      req_second_longitude <= lo2[LON_W-1:0];
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   task automatic write_radius(input logic [RADIUS_W-1:0] km);
      drain_results();
      csr_valid <= 1'b1;
      csr_sphere_radius_km <= km;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      radius_settings++;
   endtask

   function automatic int rand_lat();
      return int'($urandom_range(0, 2 * LAT_MAX)) - LAT_MAX;
   endfunction

   function automatic int rand_lon();
      return int'($urandom_range(0, 2 * LON_MAX)) - LON_MAX;
   endfunction

   task automatic random_pairs(input int count);
      int kind, la, lo;
      for (int i = 0; i < count; i++) begin
         if (i % 70 == 0) begin
            no_gaps = ($urandom_range(0, 3) == 0);
            no_stalls = ($urandom_range(0, 3) == 0);
         end
         kind = $urandom_range(0, 99);
         la = rand_lat();
         lo = rand_lon();
         if (kind < 10)
            send_pair(la, lo, la, lo);
         else if (kind < 20)
            send_pair(la, lo, -la, (lo >= 0) ? lo - LON_MAX : lo + LON_MAX);
         else if (kind < 30)
            send_pair(la, lo, la + int'($urandom_range(0, 400)) - 200,
                      lo + int'($urandom_range(0, 400)) - 200);
         else if (kind < 42)
            send_pair(int'($urandom()), int'($urandom()), int'($urandom()),
                      int'($urandom()));
         else
            send_pair(la, lo, rand_lat(), rand_lon());
      end
   endtask

   initial begin
      logic [RADIUS_W-1:0] radii [5];
      radii = '{16'd1, 16'd65535, 16'd0, 16'd6371, 16'd6371};
      radii[3] = RADIUS_W'($urandom_range(2, 65534));
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // extremes, poles, antipodes and out-of-range patterns
      send_pair(0, 0, 0, 0);
      send_pair(0, 0, 0, LON_MAX);
      send_pair(0, 0, 0, -LON_MAX);
      send_pair(LAT_MAX, 0, -LAT_MAX, 0);
      send_pair(LAT_MAX, LON_MAX, LAT_MAX, -LON_MAX);
      send_pair(-LAT_MAX, -LON_MAX, LAT_MAX, LON_MAX);
      send_pair(LAT_MAX, 0, LAT_MAX, 1000000);
      send_pair(2949120, 5898240, -2949120, -5898240);
      send_pair(0, 0, 1, 1);
      send_pair(0, 0, 0, 65536);
      send_pair(32'h007fffff, 32'h00ffffff, 32'h00800000, 32'h01000000);
      send_pair(32'h00800000, 32'h01000000, 32'h007fffff, 32'h00ffffff);
      send_pair(32'h00ffffff, 32'h01ffffff, 32'h00000000, 32'h00000000);
      send_pair(32'h00800000, 32'h01000000, 32'h00800000, 32'h01000000);
      send_pair(-LAT_MAX, 0, -LAT_MAX, LON_MAX);
      send_pair(3342336, -4849664, 3276800, 8257536);
      write_radius(16'd65535);
      send_pair(0, 0, 0, LON_MAX);
      send_pair(LAT_MAX, 0, -LAT_MAX, 0);
      send_pair(0, 0, 0, 5898240);
      write_radius(16'd0);
      send_pair(0, 0, 0, LON_MAX);
      send_pair(LAT_MAX, 123, -LAT_MAX, 456);
      write_radius(16'd6371);

      random_pairs(250);
      foreach (radii[i]) begin
         write_radius(radii[i]);
         random_pairs(200);
      end

      drain_results();
      $display("checked %0d distances over %0d radius settings, %0d mismatches",
               checked_count, radius_settings, error_count);
      if (pending_count != 0)
         $error("%0d expected distances never arrived", pending_count);
      if (error_count == 0 && pending_count == 0)
         $display("** haversine_distance_top: PASSED **");
      else
         $display("** haversine_distance_top: FAILED **");
      $finish;
   end
endmodule
